@@ rtl/fcs_pkg.sv @@
// Shared constants, queue entry type and widths for the Fletcher-32 checksum block.
`default_nettype none

package fcs_pkg;

  localparam int BYTES_PER_ITEM = 8;
  localparam int DATA_BYTES     = 8;
  localparam logic [15:0] FL_MOD = 16'hFFFF;

  localparam int KW   = $clog2(BYTES_PER_ITEM + 1);
  localparam int S1_W = $clog2(DATA_BYTES * 255 + 1);
  localparam int T_W  = $clog2(255 * DATA_BYTES * (DATA_BYTES - 1) / 2 + 1);
  localparam int W_W  = KW + S1_W;
  localparam int HW   = KW + 18;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic            start_run;
    logic [15:0]     seed_low;
    logic [15:0]     seed_high;
    logic [KW-1:0]   k;
    logic [S1_W-1:0] s1;
    logic [W_W-1:0]  w;
    logic            last_item;
  } fcs_entry_t;

endpackage

`default_nettype wire

@@ rtl/fcs_front.sv @@
// Front end: clamps the byte count and reduces one word to its byte sum and weighted sum.
`default_nettype none

module fcs_front
  import fcs_pkg::*;
(
  input  wire logic        start_run,
  input  wire logic [15:0] seed_low,
  input  wire logic [15:0] seed_high,
  input  wire logic [63:0] data_bytes,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last_item,
  output fcs_entry_t       entry
);

  logic [KW-1:0]   k;
  logic [S1_W-1:0] s1;
  logic [T_W-1:0]  t;
  logic [7:0]      b;

  always_comb begin
    if (int'(byte_count) > BYTES_PER_ITEM) begin
      k = KW'(BYTES_PER_ITEM);
    end else begin
      k = KW'(byte_count);
    end
    s1 = '0;
    t  = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      b = (i < int'(k)) ? data_bytes[8*i +: 8] : 8'd0;
      s1 = s1 + S1_W'(b);
      t  = t + T_W'(b) * T_W'(i);
    end
  end

  // weighted sum of (k - i) * b_i, written as k * S1 - sum of i * b_i
  always_comb begin
    entry.start_run = start_run;
    entry.seed_low  = seed_low;
    entry.seed_high = seed_high;
    entry.k         = k;
    entry.s1        = s1;
    entry.w         = W_W'(k) * W_W'(s1) - W_W'(t);
    entry.last_item = last_item;
  end

endmodule

`default_nettype wire

@@ rtl/fcs_queue.sv @@
// Short register queue between the front and back ends.
`default_nettype none

module fcs_queue
  import fcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire fcs_entry_t  wr_entry,
  input  wire logic        pop,
  output logic             full,
  output logic             not_empty,
  output fcs_entry_t       head
);

  fcs_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fcs_back.sv @@
// Back end: running sums with end-around reduction and the result register.
`default_nettype none

module fcs_back
  import fcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire fcs_entry_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      sum_low,
  output logic [15:0]      sum_high
);

  logic [15:0]  low_sum;
  logic [15:0]  high_sum;
  logic [15:0]  base_low;
  logic [15:0]  base_high;
  logic [16:0]  low_raw;
  logic [HW-1:0] high_raw;
  logic [16:0]  low_fold;
  logic [16:0]  high_fold;
  logic [15:0]  low_next;
  logic [15:0]  high_next;

  assign q_pop = q_valid && (!q_head.last_item || !out_valid || !out_stall);

  assign base_low  = q_head.start_run ? q_head.seed_low  : low_sum;
  assign base_high = q_head.start_run ? q_head.seed_high : high_sum;

  // 2^16 is 1 mod 65535: fold the upper bits back in, then one subtract
  always_comb begin
    low_raw   = 17'(base_low) + 17'(q_head.s1);
    high_raw  = HW'(base_high) + HW'(q_head.k) * HW'(base_low) + HW'(q_head.w);
    low_fold  = 17'(low_raw[15:0]) + 17'(low_raw[16]);
    high_fold = 17'(high_raw[15:0]) + 17'(high_raw[HW-1:16]);
    low_next  = (low_fold >= 17'(FL_MOD)) ? 16'(low_fold - 17'(FL_MOD)) : low_fold[15:0];
    high_next = (high_fold >= 17'(FL_MOD)) ? 16'(high_fold - 17'(FL_MOD))
                                          : high_fold[15:0];
    if (q_head.k == '0) begin
      low_next  = base_low;
      high_next = base_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum   <= '0;
      high_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        low_sum  <= low_next;
        high_sum <= high_next;
      end
      if (q_pop && q_head.last_item) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last_item) begin
      sum_low  <= low_next;
      sum_high <= high_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fletcher32_byte_checksum.sv @@
// Top level of the byte-wise Fletcher-32 checksum engine.
//
// Takes one word of up to eight bytes per clock, sustained unless out_stall holds
// back a result, and returns both 16-bit sums via the queue slot and the result
// register once a word marked last_item is accepted. The back end folds a whole
// word into the running sums (a small k-by-16 product, adds and an end-around
// reduction modulo 65535). start_run loads the seeds before the word's bytes; a
// word with no bytes leaves the sums unreduced: the seeds on start_run, else
// untouched. A two-entry queue splits byte reduction from the sum update, and in_stall rises only when it is full.
`default_nettype none

module fletcher32_byte_checksum
  import fcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        start_run,
  input  wire logic [15:0] seed_low,
  input  wire logic [15:0] seed_high,
  input  wire logic [63:0] data_bytes,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      sum_low,
  output logic [15:0]      sum_high
);

  fcs_entry_t front_entry;
  fcs_entry_t q_head;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  assign in_stall = q_full;

  fcs_front u_front (
    .start_run  (start_run),
    .seed_low   (seed_low),
    .seed_high  (seed_high),
    .data_bytes (data_bytes),
    .byte_count (byte_count),
    .last_item  (last_item),
    .entry      (front_entry)
  );

  fcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .wr_entry  (front_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  fcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum_low   (sum_low),
    .sum_high  (sum_high)
  );

endmodule

`default_nettype wire

@@ rtl/fcs_checker.sv @@
// Port-level checks for the checksum engine, bound to the top level.
`default_nettype none

module fcs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] sum_low,
  input wire logic [15:0] sum_high
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(sum_low) && $stable(sum_high))
    else $error("result changed while stalled");

  a_no_out_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_ready_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall rose without an accepted word");

endmodule

bind fletcher32_byte_checksum fcs_checker u_fcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .sum_low   (sum_low),
  .sum_high  (sum_high)
);

`default_nettype wire
